// ----- rtl/multi_tone_sine_generator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-tone sine generator checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_TONE_SINE_GENERATOR_TOP_ASSERT_SVH
`define MULTI_TONE_SINE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and ignored while rst is high.
`define MTSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst is high.
`define MTSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mtsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsg_pkg
// Shared constants and the elaboration-time sine table function.
// ----------------------------------------------------------------------------
package mtsg_pkg;

  localparam int DefMaxTones      = 16;
  localparam int DefSineTableBits = 10;

  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 15;
  localparam int AMP_W    = 14;
  localparam int SINE_AMP = 16383;
  localparam int CFG_IDX_W = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_IDX_W-1:0] CFG_START_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WORD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_COUNT = 2'd2;

  // Entry k of a quarter-wave table with 2^bits steps, evaluated only at
  // elaboration. A Q30 Taylor series up to x^21 is rounded half up.
  function automatic logic [AMP_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    int unsigned n;
    x = ((64'(k) * HALF_PI_Q30) + (64'd1 << (bits - 1))) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        default: term = term / 64'd420;
      endcase
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (64'(SINE_AMP) * sum + (64'd1 << 29)) >> 30;
    if (v > 64'(SINE_AMP)) begin
      v = 64'(SINE_AMP);
    end
    return v[AMP_W-1:0];
  endfunction

endpackage

// ----- rtl/mtsg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mtsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mtsg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsg_div
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module mtsg_div #(
  parameter int DW = 18,
  parameter int DV = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DV-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [DW-1:0] quo;
  logic [DV-1:0] rem;
  logic [DV-1:0] rem_next;
  logic [CW-1:0] cnt;
  logic [DV:0]   trial;
  logic          qbit;

  always_comb begin
    trial = {rem, quo[DW-1]};
    if (trial >= {1'b0, divisor}) begin
      qbit = 1'b1;
      rem_next = DV'(trial - {1'b0, divisor});
    end else begin
      qbit = 1'b0;
      rem_next = trial[DV-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CW'(DW - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], qbit};
      rem <= rem_next;
      cnt <= cnt + CW'(1);
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/multi_tone_sine_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_tone_sine_generator_top
// Averages evenly spaced sine tones from per-tone phase accumulators.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction
//  item     item_valid, item_stall, restart  in (item_stall driven here)
//  sample   sample_valid, sample_stall,      out
//           sample
//  config   cfg_write, cfg_index, cfg_data   in, write only
//
// One transaction runs the tone pipeline (one RAM read per tone, then the
// table read and the accumulate), a divider start state and the divider
// wait (one quotient bit per cycle, then done). The next transaction is
// taken only once the result has been loaded and the block is back in idle.
// All MAX_TONES phases advance on every sample, so the tone loop runs full.
// Reset clears control state, phase valid bits and the start and step words, and sets the tone count to 1.
// A finished sample waits in the output register; the next transaction is
// taken meanwhile and holds at its end only if that register is still full.
module multi_tone_sine_generator_top #(
  parameter int MAX_TONES       = mtsg_pkg::DefMaxTones,
  parameter int SINE_TABLE_BITS = mtsg_pkg::DefSineTableBits
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  restart,
  output logic                                  sample_valid,
  input  logic                                  sample_stall,
  output logic signed [mtsg_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  cfg_write,
  input  logic [mtsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mtsg_pkg::PHASE_W-1:0]          cfg_data
);

  localparam int PW     = mtsg_pkg::PHASE_W;
  localparam int AW     = mtsg_pkg::AMP_W;
  localparam int TBL_N  = 1 << SINE_TABLE_BITS;
  localparam int IDX_W  = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int C_W    = $clog2(MAX_TONES + 2);
  localparam int CNT_W  = $clog2(MAX_TONES + 1);
  localparam int TC_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int SUM_W  = $clog2(MAX_TONES * mtsg_pkg::SINE_AMP + 1) + 1;
  localparam int DW     = SUM_W - 1;
  localparam int RA_W   = SINE_TABLE_BITS + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TONE  = 3'd1;
  localparam logic [2:0] ST_DIVST = 3'd2;
  localparam logic [2:0] ST_DIVW  = 3'd3;

  function automatic logic [(TBL_N+1)*AW-1:0] build_qtbl();
    logic [(TBL_N+1)*AW-1:0] flat;
    int unsigned k;
    flat = '0;
    for (k = 0; k <= TBL_N; k++) begin
      flat[k*AW +: AW] = mtsg_pkg::sine_entry(k, SINE_TABLE_BITS);
    end
    return flat;
  endfunction

  localparam logic [(TBL_N+1)*AW-1:0] QTBL = build_qtbl();

  logic [2:0]          state;
  logic [PW-1:0]       start_word;
  logic [PW-1:0]       step_word;
  logic [4:0]          tone_count;
  logic [CNT_W-1:0]    tone_eff;
  logic [TC_W-1:0]     tc_wide;

  logic                accept;
  logic [C_W-1:0]      cyc;
  logic                issue;
  logic [IDX_W-1:0]    rd_idx;
  logic [PW-1:0]       incr;
  logic [MAX_TONES-1:0] tone_vld;
  logic                vld_q;

  logic                st1_vld;
  logic [IDX_W-1:0]    st1_idx;
  logic [PW-1:0]       st1_incr;
  logic [PW-1:0]       ram_rdata;
  logic [PW-1:0]       phase_cur;
  logic [PW-1:0]       phase_next;
  logic [SINE_TABLE_BITS-1:0] tbl_k;
  logic [RA_W-1:0]     rom_addr;

  logic                st2_vld;
  logic                st2_neg;
  logic [AW-1:0]       rom_q;
  logic signed [SUM_W-1:0] tone_val;
  logic signed [SUM_W-1:0] sum;

  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [DW-1:0]       div_quo;
  logic                div_done;
  logic [SUM_W-1:0]    quo_ext;
  logic [SUM_W-1:0]    result;
  logic                out_free;
  logic                load_out;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign issue      = (state == ST_TONE) && (cyc < C_W'(MAX_TONES));
  assign rd_idx     = cyc[IDX_W-1:0];
  assign out_free   = !sample_valid || !sample_stall;
  assign load_out   = (state == ST_DIVW) && div_done && out_free;

  // Tone count 0 acts as 1; counts above MAX_TONES saturate.
  always_comb begin
    tc_wide = TC_W'(tone_count);
    if (tc_wide == '0) begin
      tone_eff = CNT_W'(1);
    end else if (tc_wide > TC_W'(MAX_TONES)) begin
      tone_eff = CNT_W'(MAX_TONES);
    end else begin
      tone_eff = tc_wide[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_word <= '0;
      step_word  <= '0;
      tone_count <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        mtsg_pkg::CFG_START_WORD: start_word <= cfg_data;
        mtsg_pkg::CFG_STEP_WORD:  step_word  <= cfg_data;
        mtsg_pkg::CFG_TONE_COUNT: tone_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  mtsg_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_TONES)
  ) u_phase_ram (
    .clk   (clk),
    .we    (st1_vld),
    .waddr (st1_idx),
    .wdata (phase_next),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // A phase entry not written since the last restart reads as zero.
  assign phase_cur  = vld_q ? ram_rdata : '0;
  assign phase_next = phase_cur + st1_incr;
  assign tbl_k      = phase_cur[PW-3 -: SINE_TABLE_BITS];
  assign rom_addr   = phase_cur[PW-2] ? (RA_W'(TBL_N) - RA_W'(tbl_k)) : RA_W'(tbl_k);

  assign tone_val = st2_neg ? -$signed(SUM_W'(rom_q)) : $signed(SUM_W'(rom_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      st1_vld  <= 1'b0;
      st2_vld  <= 1'b0;
      tone_vld <= '0;
      sample_valid <= 1'b0;
    end else begin
      st1_vld <= issue;
      st2_vld <= st1_vld && (CNT_W'(st1_idx) < tone_eff);
      if (st1_vld) begin
        tone_vld[st1_idx] <= 1'b1;
      end
      if (load_out) begin
        sample_valid <= 1'b1;
      end else if (sample_valid && !sample_stall) begin
        sample_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (restart) begin
              tone_vld <= '0;
            end
            state <= ST_TONE;
          end
        end
        ST_TONE: begin
          if (cyc == C_W'(MAX_TONES + 1)) begin
            state <= ST_DIVST;
          end
        end
        ST_DIVST: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    vld_q    <= tone_vld[rd_idx];
    st1_idx  <= rd_idx;
    st1_incr <= incr;
    rom_q    <= QTBL[rom_addr*AW +: AW];
    st2_neg  <= phase_cur[PW-1];
    if (accept) begin
      cyc  <= '0;
      incr <= start_word;
      sum  <= '0;
    end else begin
      if (state == ST_TONE) begin
        cyc <= cyc + C_W'(1);
      end
      if (issue) begin
        incr <= incr + step_word;
      end
      if (st2_vld) begin
        sum <= sum + tone_val;
      end
    end
    if (load_out) begin
      sample <= result[mtsg_pkg::SAMPLE_W-1:0];
    end
  end

  // The divider works on the magnitude; the sign is put back afterwards so
  // the quotient truncates toward zero.
  assign div_start    = (state == ST_DIVST);
  assign div_dividend = sum[SUM_W-1] ? DW'(-sum) : DW'(sum);
  assign quo_ext      = {1'b0, div_quo};
  assign result       = sum[SUM_W-1] ? -quo_ext : quo_ext;

  mtsg_div #(
    .DW (DW),
    .DV (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (tone_eff),
    .quotient (div_quo),
    .done     (div_done)
  );

endmodule

// ----- rtl/mtsg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsg_checker
// Port-level assertions for the multi-tone sine generator, bound to the top.
// ----------------------------------------------------------------------------
`include "multi_tone_sine_generator_top_assert.svh"

module mtsg_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic [14:0] sample
);

  // A sample is produced by multi-cycle work, so the block is busy after
  // every accepted transaction.
  `MTSG_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "not busy after accept")

  // An average of sines scaled by 16383 never reaches -16384.
  `MTSG_ASSERT_IMPL(a_sample_range, sample_valid, sample != 15'h4000, "sample out of range")

  // A new result only appears at the end of a busy period.
  `MTSG_ASSERT_IMPL(a_result_after_work, $rose(sample_valid), $past(item_stall), "result without work")

  `MTSG_ASSERT_NEXT(a_sample_hold, sample_valid && sample_stall, sample_valid && $stable(sample), "stalled sample changed")

endmodule

bind multi_tone_sine_generator_top mtsg_checker u_mtsg_checker (.*);

// ----- tb/multi_tone_sine_generator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_tone_sine_generator_top_tb
// Self-checking bench for the multi-tone sine generator. A driver feeds tick
// transactions from a queue, a behavioral tone synthesizer predicts each
// averaged sample, and a monitor compares the samples in order while both
// channels idle and stall in several patterns, one with a long output hold.
// ----------------------------------------------------------------------------
module multi_tone_sine_generator_top_tb;

  localparam int NUM_TONES   = mtsg_pkg::DefMaxTones;
  localparam int TBL_BITS    = mtsg_pkg::DefSineTableBits;
  localparam int TBL_N       = 1 << TBL_BITS;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 64;
  localparam logic [mtsg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic restart = 1'b0;
  logic sample_valid;
  logic sample_stall = 1'b0;
  logic signed [mtsg_pkg::SAMPLE_W-1:0] sample;
  logic cfg_write = 1'b0;
  logic [mtsg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mtsg_pkg::PHASE_W-1:0] cfg_data = '0;

  multi_tone_sine_generator_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .restart(restart),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Synthesizer state mirrored in the bench.
  int          amp_table [0:TBL_N];
  logic [31:0] tone_phase [NUM_TONES];
  logic [31:0] start_word_q = '0;
  logic [31:0] step_word_q = '0;
  logic [4:0]  tone_count_q = 5'd1;

  bit                                   pending_ticks [$];
  logic signed [mtsg_pkg::SAMPLE_W-1:0] expected_samples [$];
  idle_mode_t                           idle_mode = IDLE_NONE;
  int                                   errors = 0;

  // Quarter-wave amplitude from a Q30 Taylor series, rounded half up.
  function automatic int quarter_amp(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    x = (64'(k) * mtsg_pkg::HALF_PI_Q30 + 64'(TBL_N / 2)) / 64'(TBL_N);
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    v = (64'(mtsg_pkg::SINE_AMP) * acc + (64'd1 << 29)) >> 30;
    if (v > 64'(mtsg_pkg::SINE_AMP)) begin
      v = 64'(mtsg_pkg::SINE_AMP);
    end
    return int'(v);
  endfunction

  function automatic int tone_sine(input logic [31:0] p);
    int unsigned k;
    int v;
    k = (p >> (30 - TBL_BITS)) & (TBL_N - 1);
    v = p[30] ? amp_table[TBL_N - k] : amp_table[k];
    return p[31] ? -v : v;
  endfunction

  // Forms one averaged sample and advances every accumulator.
  function automatic logic signed [mtsg_pkg::SAMPLE_W-1:0] synth_sample(input bit clr);
    int cnt;
    int acc;
    int avg;
    if (clr) begin
      for (int j = 0; j < NUM_TONES; j++) tone_phase[j] = '0;
    end
    cnt = int'(tone_count_q);
    if (cnt < 1) cnt = 1;
    if (cnt > NUM_TONES) cnt = NUM_TONES;
    acc = 0;
    for (int j = 0; j < cnt; j++) acc += tone_sine(tone_phase[j]);
    avg = acc / cnt;
    for (int j = 0; j < NUM_TONES; j++) begin
      tone_phase[j] = tone_phase[j] + start_word_q + 32'(j) * step_word_q;
    end
    return avg[mtsg_pkg::SAMPLE_W-1:0];
  endfunction

  initial begin
    for (int k = 0; k <= TBL_N; k++) amp_table[k] = quarter_amp(k);
    for (int j = 0; j < NUM_TONES; j++) tone_phase[j] = '0;
  end

  // Tick driver.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      restart <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_samples.push_back(synth_sample(restart));
      end
      if (item_valid && item_stall) begin
        // Hold the stalled transaction unchanged.
      end else if (pending_ticks.size() != 0 &&
                   !((idle_mode == IDLE_SEND && $urandom_range(99) < 50) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(99) < 24))) begin
        item_valid <= 1'b1;
        restart <= pending_ticks.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Sample monitor and output stall generator.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    logic signed [mtsg_pkg::SAMPLE_W-1:0] want;
    if (rst) begin
      sample_stall <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        if (expected_samples.size() == 0) begin
          $error("sample: unexpected transaction, actual %0d", sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want) begin
            $error("sample: expected %0d, actual %0d", want, sample);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        sample_stall <= 1'b1;
      end else if (idle_mode == IDLE_HOLD && !hold_done && sample_valid) begin
        // Long hold-off so the block fills up and stalls its input.
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        sample_stall <= 1'b1;
      end else begin
        sample_stall <= (idle_mode == IDLE_RECV && $urandom_range(99) < 50) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(99) < 24);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (sample_valid && !sample_stall) || cfg_write) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic write_reg(input logic [mtsg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      mtsg_pkg::CFG_START_WORD: start_word_q = data;
      mtsg_pkg::CFG_STEP_WORD:  step_word_q = data;
      mtsg_pkg::CFG_TONE_COUNT: tone_count_q = data[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_tones(input logic [31:0] start_w, input logic [31:0] step_w,
                           input logic [31:0] count);
    write_reg(mtsg_pkg::CFG_START_WORD, start_w);
    write_reg(mtsg_pkg::CFG_STEP_WORD, step_w);
    write_reg(mtsg_pkg::CFG_TONE_COUNT, count);
  endtask

  // Waits until every tick has been taken and every sample has come back.
  task automatic drain();
    while (pending_ticks.size() != 0 || item_valid || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_ticks(input int n, input int restart_pct);
    for (int i = 0; i < n; i++) pending_ticks.push_back($urandom_range(99) < restart_pct);
  endtask

  initial begin
    logic [31:0] count_w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset configuration: one tone at zero frequency.
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    drain();

    // Quarter-turn steps walk through zero and both peaks.
    set_tones(32'h4000_0000, 32'h0, 32'd1);
    push_ticks(5, 0);
    pending_ticks.push_back(1'b1);
    push_ticks(2, 0);
    drain();

    // Largest words with all sixteen tones.
    set_tones(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16);
    push_ticks(3, 0);
    pending_ticks.push_back(1'b1);
    drain();

    // Zero and oversized tone counts, and a write to the unused index.
    set_tones(32'h1234_5678, 32'h0800_0000, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    push_ticks(3, 0);
    drain();
    write_reg(mtsg_pkg::CFG_TONE_COUNT, 32'd31);
    push_ticks(3, 0);
    drain();
    write_reg(mtsg_pkg::CFG_TONE_COUNT, 32'd17);
    write_reg(CFG_UNUSED, 32'h0);
    pending_ticks.push_back(1'b1);
    push_ticks(2, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(99) < 75) begin
        count_w = $urandom_range(16, 1);
      end else begin
        count_w = ($urandom_range(1) != 0) ? 32'd0 : 32'($urandom_range(31, 17));
      end
      if (ph == 1) count_w = 32'd16;
      if (ph == 2) count_w = 32'd1;
      set_tones($urandom, $urandom, count_w);
      if (ph == 4) begin
        idle_mode = IDLE_HOLD;
      end else begin
        idle_mode = idle_mode_t'(ph % 4);
      end
      push_ticks(55, 8);
      drain();
      idle_mode = IDLE_NONE;
    end

    if (errors == 0 && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
